/* hw/rtl/tbpf_pkg.sv */
package tbpf_pkg;

	localparam int MEM_DEPTH = 16384;
	localparam int MEM_AW    = 14;

	// Fixed upper bits of the table regions, as offsets into video memory.
	localparam logic [1:0] NAME_HI     = 2'b10;     // 0x2000 region
	localparam logic [3:0] ATTR_HI     = 4'b1100;   // 0x3000 region
	localparam logic [9:0] PAL_HI      = 10'h350;   // 0x3500 region, 16 bytes
	localparam logic [MEM_AW-1:0] BACKDROP_OFF = 14'h3500;

	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_PIXEL = 1'b1;

	typedef struct packed {
		logic        mode;
		logic [13:0] mem_offset;
		logic [7:0]  mem_data;
		logic [8:0]  pixel_x;
		logic [8:0]  pixel_y;
	} req_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [5:0] colour_index;
		logic       from_backdrop;
	} px_t;

	// 85 * c for a 2-bit channel is the channel repeated four times.
	function automatic logic [7:0] expand2(input logic [1:0] c);
		return {c, c, c, c};
	endfunction

endpackage

/* hw/rtl/tbpf_ram.sv */
module tbpf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

/* hw/rtl/tbpf_out_buf.sv */
module tbpf_out_buf (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            res_valid,
	input  tbpf_pkg::px_t   res,
	output logic            advance,
	output logic            px_valid,
	input  logic            px_ready,
	output tbpf_pkg::px_t   px
);
	import tbpf_pkg::*;

	logic out_valid_q;
	logic skid_valid_q;
	px_t  out_q;
	px_t  skid_q;
	logic out_free;

	// The pipeline only moves while the spare slot is empty, so a result
	// never arrives when both slots are occupied.
	assign advance  = !skid_valid_q;
	assign out_free = !out_valid_q || px_ready;
	assign px_valid = out_valid_q;
	assign px       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= res_valid;
			end
		end else if (res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (res_valid) begin
			skid_q <= res;
		end
	end

endmodule

/* hw/rtl/tile_background_pixel_fetch.sv */
// Tile-map background pixel fetch, two bits per pixel.
//
// The req channel carries one request per req_ready cycle. A write (mode 0)
// stores mem_data at mem_offset of the 16 KiB video memory and gives no
// result. A pixel request (mode 1) gives one px result: the colour of point
// (pixel_x, pixel_y) on the 512x512 plane, as 6-bit index and 8-bit RGB.
// Results leave in request order; writes take effect for every later pixel.
//
// Throughput is one request per clock while req_ready is high. A pixel
// passes three dependent video memory reads (name and attribute bytes, the
// two pattern planes, then the palette byte), each in a stage of its own,
// and the result is registered once more at the output. Stages 0, 1 and 2
// each own a copy of video memory; a write updates each copy as it passes
// that stage, which keeps ordering exact.
//
// Reset clears only the valid bits; video memory is not cleared and must
// be written before it is read. When the receiver stalls, one extra result
// is caught in a spare slot and then the whole pipeline holds; req_ready
// comes from a register and does not depend on px_ready in the same cycle.
module tile_background_pixel_fetch (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  tbpf_pkg::req_t  req,
	output logic            px_valid,
	input  logic            px_ready,
	output tbpf_pkg::px_t   px
);
	import tbpf_pkg::*;

	logic advance;
	logic accept;

	assign req_ready = advance;
	assign accept    = req_valid && advance;

	// Stage 0: form the name and attribute table offsets from the point.
	logic [MEM_AW-1:0] name_off;
	logic [MEM_AW-1:0] attr_off;

	assign name_off = {NAME_HI, req.pixel_y[8], req.pixel_x[8],
		req.pixel_y[7:3], req.pixel_x[7:3]};
	assign attr_off = {ATTR_HI, req.pixel_y[8], req.pixel_x[8],
		req.pixel_y[7:4], req.pixel_x[7:4]};

	logic [7:0] tile_s1;
	logic [7:0] attr_s1;

	tbpf_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_ram_map (
		.clk     (clk),
		.we      (accept && (req.mode == MODE_WRITE)),
		.waddr   (req.mem_offset),
		.wdata   (req.mem_data),
		.re      (advance),
		.raddr_a (name_off),
		.raddr_b (attr_off),
		.rdata_a (tile_s1),
		.rdata_b (attr_s1)
	);

	// Stage 1: pick the palette number and address both pattern planes.
	logic              valid_s1;
	logic              mode_s1;
	logic [13:0]       woff_s1;
	logic [7:0]        wdata_s1;
	logic [1:0]        quad_s1;
	logic [2:0]        row_s1;
	logic [2:0]        col_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mode_s1  <= req.mode;
			woff_s1  <= req.mem_offset;
			wdata_s1 <= req.mem_data;
			quad_s1  <= {req.pixel_y[3], req.pixel_x[3]};
			row_s1   <= req.pixel_y[2:0];
			col_s1   <= req.pixel_x[2:0];
		end
	end

	// The top-left quadrant sits in bits 7:6, so the shift is twice the
	// inverted quadrant number.
	logic [7:0]        attr_shifted;
	logic [1:0]        pal_s1;
	logic [MEM_AW-1:0] plane0_off;
	logic [MEM_AW-1:0] plane1_off;

	assign attr_shifted = attr_s1 >> {~quad_s1, 1'b0};
	assign pal_s1       = attr_shifted[1:0];
	assign plane0_off   = {2'b00, tile_s1, 1'b0, row_s1};
	assign plane1_off   = {2'b00, tile_s1, 1'b1, row_s1};

	logic [7:0] plane0_s2;
	logic [7:0] plane1_s2;

	tbpf_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_ram_pattern (
		.clk     (clk),
		.we      (advance && valid_s1 && (mode_s1 == MODE_WRITE)),
		.waddr   (woff_s1),
		.wdata   (wdata_s1),
		.re      (advance),
		.raddr_a (plane0_off),
		.raddr_b (plane1_off),
		.rdata_a (plane0_s2),
		.rdata_b (plane1_s2)
	);

	// Stage 2: build the 2-bit pattern entry and address the palette.
	// The backdrop byte is read alongside and chosen one stage later.
	logic              valid_s2;
	logic              mode_s2;
	logic [13:0]       woff_s2;
	logic [7:0]        wdata_s2;
	logic [1:0]        pal_s2;
	logic [2:0]        col_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mode_s2  <= mode_s1;
			woff_s2  <= woff_s1;
			wdata_s2 <= wdata_s1;
			pal_s2   <= pal_s1;
			col_s2   <= col_s1;
		end
	end

	logic [1:0]        entry_s2;
	logic [MEM_AW-1:0] pal_off;

	// Pixel 0 of a row is the most significant bit of each plane byte.
	assign entry_s2 = {plane1_s2[~col_s2], plane0_s2[~col_s2]};
	assign pal_off  = {PAL_HI, pal_s2, entry_s2};

	logic [7:0] pal_byte_s3;
	logic [7:0] backdrop_s3;

	tbpf_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_ram_palette (
		.clk     (clk),
		.we      (advance && valid_s2 && (mode_s2 == MODE_WRITE)),
		.waddr   (woff_s2),
		.wdata   (wdata_s2),
		.re      (advance),
		.raddr_a (pal_off),
		.raddr_b (BACKDROP_OFF),
		.rdata_a (pal_byte_s3),
		.rdata_b (backdrop_s3)
	);

	// Stage 3: choose backdrop or palette colour and expand it to RGB.
	logic valid_s3;
	logic mode_s3;
	logic backdrop_sel_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mode_s3         <= mode_s2;
			backdrop_sel_s3 <= (entry_s2 == 2'b00);
		end
	end

	logic [7:0] colour;
	px_t        res;
	logic       res_valid;

	assign colour = backdrop_sel_s3 ? backdrop_s3 : pal_byte_s3;

	always_comb begin
		res.red           = expand2(colour[5:4]);
		res.green         = expand2(colour[3:2]);
		res.blue          = expand2(colour[1:0]);
		res.colour_index  = colour[5:0];
		res.from_backdrop = backdrop_sel_s3;
	end

	assign res_valid = advance && valid_s3 && (mode_s3 == MODE_PIXEL);

	tbpf_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.advance   (advance),
		.px_valid  (px_valid),
		.px_ready  (px_ready),
		.px        (px)
	);

endmodule
